### hw/rtl/utf8v_pkg.sv
// Package: shared types and constants for the UTF-8 tag value validator.
package utf8v_pkg;

  localparam int unsigned LEN_BITS_DEF = 17;
  localparam int unsigned MAX_LEN_W    = 16;
  localparam int unsigned KEPT_W       = 17;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST = 16'd4096;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_90    = 8'h90;

  typedef enum logic [2:0] {
    LC_NONE = 3'd0,
    LC_E0   = 3'd1,
    LC_ED   = 3'd2,
    LC_F0   = 3'd3,
    LC_F4   = 3'd4
  } lead_class_t;

  typedef struct packed {
    logic [1:0]  pending_cont;
    lead_class_t lead_class;
    logic        seq_error;
    logic        nul_seen;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_CLR = '{
    pending_cont: 2'd0,
    lead_class:   LC_NONE,
    seq_error:    1'b0,
    nul_seen:     1'b0
  };

endpackage

### hw/rtl/utf8v_step.sv
// Combinational per-byte decoder step, length counters and end-of-value verdict.
module utf8v_step import utf8v_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  dec_state_t           state_i,
  input  logic [LEN_BITS-1:0]  total_i,
  input  logic [LEN_BITS-1:0]  prefix_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 has_byte_i,
  input  logic                 last_i,
  input  logic [MAX_LEN_W-1:0] max_len_i,
  output dec_state_t           state_o,
  output logic [LEN_BITS-1:0]  total_o,
  output logic [LEN_BITS-1:0]  prefix_o,
  output logic                 valid_res_o,
  output logic [KEPT_W-1:0]    kept_len_o
);

  localparam logic [LEN_BITS-1:0] SAT_MAX = LEN_BITS'(1) << (LEN_BITS - 1);
  localparam int unsigned CMP_W = (LEN_BITS > MAX_LEN_W) ? LEN_BITS : MAX_LEN_W;

  dec_state_t          chk;
  dec_state_t          upd;
  logic [LEN_BITS-1:0] total_upd;
  logic [LEN_BITS-1:0] prefix_upd;
  logic                keep;
  logic                bad;

  always_comb begin
    chk = state_i;
    bad = 1'b0;
    if (!state_i.seq_error) begin
      if (state_i.pending_cont != 2'd0) begin
        bad = (data_byte_i & CONT_MASK) != CONT_TAG;
        unique case (state_i.lead_class)
          LC_E0:   bad = bad || (data_byte_i < CONT_A0);
          LC_ED:   bad = bad || (data_byte_i >= CONT_A0);
          LC_F0:   bad = bad || (data_byte_i < CONT_90);
          LC_F4:   bad = bad || (data_byte_i >= CONT_90);
          default: bad = bad;
        endcase
        chk.lead_class = LC_NONE;
        if (bad) begin
          chk.seq_error    = 1'b1;
          chk.pending_cont = 2'd0;
        end else begin
          chk.pending_cont = state_i.pending_cont - 2'd1;
        end
      end else if (data_byte_i < CONT_TAG) begin
        chk = state_i;
      end else if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
        chk.pending_cont = 2'd1;
        chk.lead_class   = LC_NONE;
      end else if (data_byte_i >= LEAD3_LO && data_byte_i <= LEAD3_HI) begin
        chk.pending_cont = 2'd2;
        if (data_byte_i == LEAD3_LO) begin
          chk.lead_class = LC_E0;
        end else if (data_byte_i == LEAD3_SURR) begin
          chk.lead_class = LC_ED;
        end else begin
          chk.lead_class = LC_NONE;
        end
      end else if (data_byte_i >= LEAD4_LO && data_byte_i <= LEAD4_HI) begin
        chk.pending_cont = 2'd3;
        if (data_byte_i == LEAD4_LO) begin
          chk.lead_class = LC_F0;
        end else if (data_byte_i == LEAD4_HI) begin
          chk.lead_class = LC_F4;
        end else begin
          chk.lead_class = LC_NONE;
        end
      end else begin
        chk.seq_error = 1'b1;
      end
    end
  end

  assign keep = has_byte_i && !state_i.nul_seen && (data_byte_i != 8'd0);

  always_comb begin
    upd        = state_i;
    total_upd  = total_i;
    prefix_upd = prefix_i;
    if (has_byte_i) begin
      if (total_i < SAT_MAX) begin
        total_upd = total_i + LEN_BITS'(1);
      end
      if (!state_i.nul_seen && data_byte_i == 8'd0) begin
        upd.nul_seen = 1'b1;
      end
      if (keep) begin
        upd = chk;
        if (prefix_i < SAT_MAX) begin
          prefix_upd = prefix_i + LEN_BITS'(1);
        end
      end
    end
  end

  assign valid_res_o = !upd.seq_error && (upd.pending_cont == 2'd0) &&
                       (CMP_W'(total_upd) <= CMP_W'(max_len_i));
  assign kept_len_o  = KEPT_W'(prefix_upd);

  assign state_o  = last_i ? DEC_STATE_CLR : upd;
  assign total_o  = last_i ? '0 : total_upd;
  assign prefix_o = last_i ? '0 : prefix_upd;

endmodule

### hw/rtl/utf8v_out_stage.sv
// Result register that holds a verdict until the downstream side takes it.
module utf8v_out_stage import utf8v_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  logic              valid_res_i,
  input  logic [KEPT_W-1:0] kept_len_i,
  output logic              free_o,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_valid_res,
  output logic [KEPT_W-1:0] out_kept_len
);

  logic              valid_r;
  logic              valid_nxt;
  logic              res_r;
  logic [KEPT_W-1:0] len_r;

  assign free_o = !valid_r || !out_stall;

  always_comb begin
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= valid_res_i;
      len_r <= kept_len_i;
    end
  end

  assign out_valid     = valid_r;
  assign out_valid_res = res_r;
  assign out_kept_len  = len_r;

endmodule

### hw/rtl/utf8_tag_value_validator.sv
// Top level of the UTF-8 tag value validator: input register, decoder state and result stage.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid, in_stall  | in_data_byte, in_has_byte, in_last
//   out_    | output    | out_valid, out_stall| out_valid_res, out_kept_len
//   cfg_    | input     | cfg_we              | cfg_wdata (max_value_len)
//
// One byte is taken every cycle unless in_stall is high; a result goes from the input register
// to the result register. The decoder state and counters update from the input register.
// Reset is synchronous and clears the state; max_value_len returns to 4096.
// A stalled result holds the input register only when it carries a last item.
module utf8_tag_value_validator import utf8v_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MAX_LEN_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_has_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_valid_res,
  output logic [KEPT_W-1:0]    out_kept_len
);

  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_has_r;
  logic                 s1_last_r;
  logic                 s1_adv;
  logic                 in_take;
  logic                 out_free;

  dec_state_t           state_r;
  dec_state_t           state_nxt;
  logic [LEN_BITS-1:0]  total_r;
  logic [LEN_BITS-1:0]  total_nxt;
  logic [LEN_BITS-1:0]  prefix_r;
  logic [LEN_BITS-1:0]  prefix_nxt;
  logic                 res_valid;
  logic [KEPT_W-1:0]    res_len;

  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last;
    end
  end

  utf8v_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .state_i     (state_r),
    .total_i     (total_r),
    .prefix_i    (prefix_r),
    .data_byte_i (s1_byte_r),
    .has_byte_i  (s1_has_r),
    .last_i      (s1_last_r),
    .max_len_i   (max_len_r),
    .state_o     (state_nxt),
    .total_o     (total_nxt),
    .prefix_o    (prefix_nxt),
    .valid_res_o (res_valid),
    .kept_len_o  (res_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= DEC_STATE_CLR;
      total_r  <= '0;
      prefix_r <= '0;
    end else if (s1_adv) begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      prefix_r <= prefix_nxt;
    end
  end

  utf8v_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_i        (s1_adv && s1_last_r),
    .valid_res_i   (res_valid),
    .kept_len_i    (res_len),
    .free_o        (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_kept_len  (out_kept_len)
  );

endmodule
